FILE: hw/rtl/sgpg_pkg.sv
// Package for the groove spiral point generator.
// Holds shared constants, codes, the CORDIC arctangent table, a 24-bit saturation helper and the sequencer states.
package sgpg_pkg;

    localparam int PATH_SPLIT_DEF    = 1000;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam logic [3:0] REG_CENTER  = 4'd0;
    localparam logic [3:0] REG_START   = 4'd1;
    localparam logic [3:0] REG_INNER   = 4'd2;
    localparam logic [3:0] REG_AMP     = 4'd3;
    localparam logic [3:0] REG_ASTEP   = 4'd4;
    localparam logic [3:0] REG_RSTEP   = 4'd5;
    localparam logic [3:0] REG_MINDIST = 4'd6;
    localparam logic [3:0] REG_TOOL    = 4'd7;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CLIP  = 2'd2;

    localparam logic FUNC_START = 1'b0;

    localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMP,
        ST_SCALE,
        ST_FOLD,
        ST_ROT,
        ST_ROUND,
        ST_DIST_X,
        ST_DIST_Y,
        ST_DECIDE,
        ST_OUT1,
        ST_OUT2
    } t_state;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] s);
        logic signed [33:0] v;
        case (s)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [27:0] v);
        logic [23:0] r;
        if (v < 0) begin
            r = 24'd0;
        end else if (v > 28'sd16777215) begin
            r = 24'hFFFFFF;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sgpg_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle over a shared add/shift unit.
// Depends on sgpg_pkg for the arctangent table.
module sgpg_cordic #(
    parameter int CORDIC_STAGES = sgpg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic signed [47:0]  i_x,
    input  logic signed [33:0]  i_z,
    output logic                o_done,
    output logic signed [47:0]  o_x,
    output logic signed [47:0]  o_y
);
    import sgpg_pkg::*;

    localparam int CW = $clog2(CORDIC_STAGES + 1);

    logic signed [47:0] r_x, r_y, n_x, n_y;
    logic signed [33:0] r_z, n_z;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic [4:0]         w_s;

    assign w_s = 5'(r_cnt);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_cnt = r_cnt;
        n_busy = r_busy;
        if (i_load) begin
            n_x = i_x;
            n_y = '0;
            n_z = i_z;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - (r_y >>> w_s);
                n_y = r_y + (r_x >>> w_s);
                n_z = r_z - atan_turn(w_s);
            end else begin
                n_x = r_x + (r_y >>> w_s);
                n_y = r_y - (r_x >>> w_s);
                n_z = r_z + atan_turn(w_s);
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(CORDIC_STAGES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done = !r_busy && !i_load;
    assign o_x = r_x;
    assign o_y = r_y;
endmodule

FILE: hw/rtl/spiral_groove_point_generator.sv
// Top level of the groove spiral point generator: config registers, sequencer, output register.
// Depends on sgpg_pkg and sgpg_cordic.
//
// A start transaction, a clipped sample or an ignored sample is handled in ST_IDLE. A rotated
// sample passes through ST_AMP, ST_SCALE, ST_FOLD, ST_ROT, ST_ROUND, ST_DIST_X, ST_DIST_Y,
// ST_DECIDE and ST_OUT1, ST_ROT lasting while the iterative CORDIC does one micro-rotation per
// cycle, and ST_OUT2 too when it yields two results. A result may also wait on i_ready. The
// block takes one item at a time: o_ready is low from acceptance until the last result of the
// item has been taken. A sample yields zero, one or two results; o_last marks the final one.
module spiral_groove_point_generator #(
    parameter int PATH_SPLIT    = sgpg_pkg::PATH_SPLIT_DEF,
    parameter int CORDIC_STAGES = sgpg_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [35:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic signed [15:0] i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_x_coord,
    output logic [23:0] o_y_coord,
    output logic [1:0]  o_kind,
    output logic        o_last
);
    import sgpg_pkg::*;

    localparam int SW = $clog2(PATH_SPLIT);

    logic [23:0] r_center, r_start, r_inner, r_amp, r_mindist;
    logic [31:0] r_astep;
    logic [35:0] r_rstep;
    logic        r_tool;

    logic [47:0] r_radius;
    logic [31:0] r_phase;
    logic [23:0] r_prev_x, r_prev_y;
    logic [SW-1:0] r_split;
    logic        r_past, r_clip;

    t_state r_st, n_st;
    logic signed [15:0] r_smp;
    logic signed [47:0] r_acc;   // shared product/work register
    logic signed [33:0] r_ang;
    logic [23:0] r_px, r_py;
    logic [49:0] r_d2;
    logic        r_emit, r_dosplit;

    logic [23:0] r_ox, r_oy;
    logic [1:0]  r_okind;
    logic        r_olast, r_ovalid;

    logic        w_cload, w_cdone;
    logic signed [47:0] w_cx, w_cy;
    logic signed [26:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [58:0] w_prod;
    logic signed [24:0] w_dd;
    logic        w_acc_in, w_out_free, w_oload;
    logic        w_fold;
    logic signed [47:0] w_cx_in;
    logic signed [33:0] w_cz_in;

    // fold by a half turn when the phase lies outside [-1/4, 1/4) of a turn
    assign w_fold = (r_phase + 32'h4000_0000) >= 32'h8000_0000;
    assign w_cx_in = w_fold ? -r_acc : r_acc;
    assign w_cz_in = w_fold ? 34'($signed(r_phase + 32'h8000_0000)) : r_ang;

    sgpg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_cload),
        .i_x(w_cx_in), .i_z(w_cz_in), .o_done(w_cdone), .o_x(w_cx), .o_y(w_cy)
    );

    assign o_cfg_ready = 1'b1;
    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready = (r_st == ST_IDLE) && w_out_free;
    assign w_acc_in = i_valid && o_ready;
    assign w_cload = (r_st == ST_FOLD);

    // shared multiplier: amplitude, inverse gain, then squared distances
    assign w_dd = (r_st == ST_DIST_X) ? $signed({1'b0, r_px}) - $signed({1'b0, r_prev_x})
                                      : $signed({1'b0, r_py}) - $signed({1'b0, r_prev_y});
    always_comb begin
        case (r_st)
            ST_AMP: begin
                w_mul_a = 27'(r_smp);
                w_mul_b = $signed({8'd0, r_amp});
            end
            ST_SCALE: begin
                w_mul_a = 27'(r_acc);
                w_mul_b = INV_GAIN;
            end
            default: begin
                w_mul_a = 27'(w_dd);
                w_mul_b = 32'(w_dd);
            end
        endcase
    end
    assign w_prod = 59'(w_mul_a) * 59'(w_mul_b);

    // load the output register with a new result
    always_comb begin
        case (r_st)
            ST_IDLE: w_oload = w_acc_in && (i_func == FUNC_START
                                            || (!r_clip && r_radius <= {r_inner, 24'd0}));
            ST_OUT1: w_oload = w_out_free && (r_emit || r_dosplit);
            ST_OUT2: w_oload = w_out_free;
            default: w_oload = 1'b0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_acc_in) begin
                    if (i_func == FUNC_START || r_clip
                        || r_radius <= {r_inner, 24'd0}) begin
                        n_st = ST_IDLE;
                    end else begin
                        n_st = ST_AMP;
                    end
                end
            end
            ST_AMP:    n_st = ST_SCALE;
            ST_SCALE:  n_st = ST_FOLD;
            ST_FOLD:   n_st = ST_ROT;
            ST_ROT:    n_st = w_cdone ? ST_ROUND : ST_ROT;
            ST_ROUND:  n_st = ST_DIST_X;
            ST_DIST_X: n_st = ST_DIST_Y;
            ST_DIST_Y: n_st = ST_DECIDE;
            ST_DECIDE: n_st = ST_OUT1;
            ST_OUT1: begin
                if (w_out_free) begin
                    n_st = (r_emit && r_dosplit) ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2:   n_st = w_out_free ? ST_IDLE : ST_OUT2;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_center <= '0; r_start <= '0; r_inner <= '0; r_amp <= '0;
            r_astep <= '0; r_rstep <= '0; r_mindist <= '0; r_tool <= 1'b0;
            r_radius <= '0; r_phase <= '0; r_prev_x <= '0; r_prev_y <= '0;
            r_split <= '0; r_past <= 1'b0; r_clip <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CENTER:  r_center <= i_cfg_data[23:0];
                    REG_START:   r_start <= i_cfg_data[23:0];
                    REG_INNER:   r_inner <= i_cfg_data[23:0];
                    REG_AMP:     r_amp <= i_cfg_data[23:0];
                    REG_ASTEP:   r_astep <= i_cfg_data[31:0];
                    REG_RSTEP:   r_rstep <= i_cfg_data;
                    REG_MINDIST: r_mindist <= i_cfg_data[23:0];
                    REG_TOOL:    r_tool <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        r_smp <= i_sample;
                        if (i_func == FUNC_START) begin
                            r_radius <= {r_start, 24'd0};
                            r_phase <= '0;
                            r_split <= '0;
                            r_past <= 1'b0;
                            r_clip <= 1'b0;
                            r_prev_x <= sat24(28'({1'b0, r_center}) + 28'({1'b0, r_start}));
                            r_prev_y <= r_center;
                            r_ox <= sat24(28'({1'b0, r_center}) + 28'({1'b0, r_start}));
                            r_oy <= r_center;
                            r_okind <= KIND_START;
                            r_olast <= 1'b1;
                        end else if (!r_clip && r_radius <= {r_inner, 24'd0}) begin
                            r_clip <= 1'b1;
                            r_ox <= '0;
                            r_oy <= '0;
                            r_okind <= KIND_CLIP;
                            r_olast <= 1'b1;
                        end
                    end
                end
                ST_AMP: begin
                    // radius integer part plus floor(sample*amp/2^15)
                    r_acc <= 48'($signed({1'b0, r_radius[47:24]})) + 48'(w_prod >>> 15);
                end
                ST_SCALE: begin
                    r_acc <= 48'(w_prod >>> 14);
                    r_ang <= 34'($signed(r_phase));
                end
                ST_ROUND: begin
                    r_px <= sat24(28'((w_cx + 48'sd32768) >>> 16) + 28'({1'b0, r_center}));
                    r_py <= sat24(28'((w_cy + 48'sd32768) >>> 16) + 28'({1'b0, r_center}));
                end
                ST_DIST_X: r_d2 <= 50'(w_prod);
                ST_DIST_Y: r_d2 <= r_d2 + 50'(w_prod);
                ST_DECIDE: begin
                    r_emit <= r_tool || (r_d2 >= 50'({r_mindist, 12'd0}));
                    r_dosplit <= !r_tool && r_past && (r_split == '0);
                    if (r_split == SW'(PATH_SPLIT - 1)) begin
                        r_split <= '0;
                        r_past <= 1'b1;
                    end else begin
                        r_split <= r_split + 1'b1;
                    end
                    r_phase <= r_phase - r_astep;
                    r_radius <= (r_radius > 48'(r_rstep)) ? r_radius - 48'(r_rstep) : '0;
                end
                ST_OUT1: begin
                    if (w_out_free && (r_emit || r_dosplit)) begin
                        r_ox <= r_px;
                        r_oy <= r_py;
                        r_okind <= r_emit ? KIND_POINT : KIND_START;
                        r_olast <= !(r_emit && r_dosplit);
                        if (r_emit) begin
                            r_prev_x <= r_px;
                            r_prev_y <= r_py;
                        end
                    end
                end
                ST_OUT2: begin
                    if (w_out_free) begin
                        r_okind <= KIND_START;
                        r_olast <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_x_coord = r_ox;
    assign o_y_coord = r_oy;
    assign o_kind = r_okind;
    assign o_last = r_olast;
endmodule
